[rtl/limited_pointer_sharer_table_core_assert.svh]
// Assertion macros for the sharer table core.
// Both expect signals named clk and arst_n in the scope where they are used.
`ifndef LIMITED_POINTER_SHARER_TABLE_CORE_ASSERT_SVH
`define LIMITED_POINTER_SHARER_TABLE_CORE_ASSERT_SVH

// Same-cycle implication
`define LPST_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sharer table check failed");

// Next-cycle implication
`define LPST_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sharer table check failed");

`endif

[rtl/lpst_pkg.sv]
package lpst_pkg;

	// Table geometry
	localparam int MAX_SHARERS  = 8;
	localparam int TILE_ID_BITS = 10;
	localparam int SLOT_W       = (MAX_SHARERS > 1) ? $clog2(MAX_SHARERS) : 1;
	localparam int SCAN_W       = $clog2(MAX_SHARERS + 1);

	// Fixed field widths of the stream payload
	localparam int FIELD_ID_W   = 10;
	localparam int ACTION_W     = 2;
	localparam int STATUS_W     = 2;
	localparam int COUNT_W      = 4;
	localparam int IN_TDATA_W   = 16;
	localparam int OUT_TDATA_W  = 24;

	typedef logic [TILE_ID_BITS-1:0] id_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_QUERY  = 2'd0,
		ACT_ADD    = 2'd1,
		ACT_REMOVE = 2'd2,
		ACT_LIST   = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_DUP       = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	// One result item on its way to the output register
	typedef struct packed {
		status_t                 status;
		logic                    present;
		logic                    listed_valid;
		logic [FIELD_ID_W-1:0]   listed_sharer;
		logic                    last;
		logic [COUNT_W-1:0]      sharer_count;
	} res_t;

endpackage

[rtl/lpst_id_ram.sv]
module lpst_id_ram #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 10,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port, holds while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[rtl/lpst_ctrl.sv]
module lpst_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [lpst_pkg::ACTION_W-1:0]     in_action,
	input  logic [lpst_pkg::FIELD_ID_W-1:0]   in_id,
	output logic                              ram_rd_en,
	output logic [lpst_pkg::SLOT_W-1:0]       ram_rd_addr,
	input  lpst_pkg::id_t                     ram_rd_data,
	output logic                              ram_wr_en,
	output logic [lpst_pkg::SLOT_W-1:0]       ram_wr_addr,
	output lpst_pkg::id_t                     ram_wr_data,
	output logic                              res_push,
	output lpst_pkg::res_t                    res,
	input  logic                              res_ready
);

	lpst_pkg::state_t                       state_q, state_d;
	lpst_pkg::action_t                      action_q;
	lpst_pkg::id_t                          id_q;
	logic [lpst_pkg::SCAN_W-1:0]            rd_cnt_q;
	logic                                   cmp_vld_s2;
	logic [lpst_pkg::SLOT_W-1:0]            cmp_idx_s2;
	logic                                   hit_q;
	logic [lpst_pkg::SLOT_W-1:0]            hit_idx_q;
	logic [lpst_pkg::MAX_SHARERS-1:0]       valid_q;
	logic [lpst_pkg::COUNT_W-1:0]           count_q;

	logic                                   scan_more;
	logic                                   slot_live;
	logic                                   list_emit;
	logic                                   match;
	logic                                   higher;
	logic                                   advance;
	logic                                   full;
	logic [lpst_pkg::SLOT_W-1:0]            free_idx;
	logic                                   upd_add;
	logic                                   upd_rem;

	// Scan bookkeeping
	assign scan_more = rd_cnt_q != lpst_pkg::SCAN_W'(lpst_pkg::MAX_SHARERS);
	assign slot_live = cmp_vld_s2 && valid_q[cmp_idx_s2];
	assign match     = slot_live && (ram_rd_data == id_q);
	assign list_emit = (state_q == lpst_pkg::S_SCAN) && (action_q == lpst_pkg::ACT_LIST)
		&& slot_live;
	assign advance   = (state_q == lpst_pkg::S_SCAN) && (!list_emit || res_ready);
	assign full      = &valid_q;

	// Look for any held slot above the one being listed
	always_comb begin
		higher = 1'b0;
		for (int j = 0; j < lpst_pkg::MAX_SHARERS; j++) begin
			if ((j > int'(cmp_idx_s2)) && valid_q[j]) begin
				higher = 1'b1;
			end
		end
	end

	// Lowest free slot
	always_comb begin
		free_idx = '0;
		for (int j = lpst_pkg::MAX_SHARERS - 1; j >= 0; j--) begin
			if (!valid_q[j]) begin
				free_idx = lpst_pkg::SLOT_W'(j);
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lpst_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = lpst_pkg::S_SCAN;
				end
			end
			lpst_pkg::S_SCAN: begin
				if (!scan_more && !cmp_vld_s2) begin
					state_d = lpst_pkg::S_DONE;
				end
			end
			lpst_pkg::S_DONE: begin
				if ((action_q == lpst_pkg::ACT_LIST && valid_q != '0) || res_ready) begin
					state_d = lpst_pkg::S_IDLE;
				end
			end
			default: state_d = lpst_pkg::S_IDLE;
		endcase
	end

	// Outputs: reads, writes and result items
	always_comb begin
		in_ready    = 1'b0;
		ram_rd_en   = 1'b0;
		ram_rd_addr = rd_cnt_q[lpst_pkg::SLOT_W-1:0];
		ram_wr_en   = 1'b0;
		ram_wr_addr = free_idx;
		ram_wr_data = id_q;
		res_push    = 1'b0;
		upd_add     = 1'b0;
		upd_rem     = 1'b0;
		res         = '0;
		res.status       = lpst_pkg::ST_OK;
		res.sharer_count = count_q;
		case (state_q)
			lpst_pkg::S_IDLE: begin
				in_ready = 1'b1;
			end
			lpst_pkg::S_SCAN: begin
				ram_rd_en = advance && scan_more;
				if (list_emit) begin
					res_push          = 1'b1;
					res.listed_valid  = 1'b1;
					res.listed_sharer = lpst_pkg::FIELD_ID_W'(ram_rd_data);
					res.last          = !higher;
				end
			end
			lpst_pkg::S_DONE: begin
				res.last = 1'b1;
				case (action_q)
					lpst_pkg::ACT_QUERY: begin
						res_push    = 1'b1;
						res.present = hit_q;
					end
					lpst_pkg::ACT_ADD: begin
						res_push = 1'b1;
						if (hit_q) begin
							res.status = lpst_pkg::ST_DUP;
						end else if (full) begin
							res.status = lpst_pkg::ST_FULL;
						end else begin
							res.sharer_count = lpst_pkg::COUNT_W'(count_q + 1'b1);
							upd_add          = res_ready;
							ram_wr_en        = res_ready;
						end
					end
					lpst_pkg::ACT_REMOVE: begin
						res_push = 1'b1;
						if (!hit_q) begin
							res.status = lpst_pkg::ST_NOT_FOUND;
						end else begin
							res.sharer_count = lpst_pkg::COUNT_W'(count_q - 1'b1);
							upd_rem          = res_ready;
						end
					end
					lpst_pkg::ACT_LIST: begin
						// Empty table still closes the list with one marker item
						res_push = (valid_q == '0);
					end
					default: res_push = 1'b0;
				endcase
			end
			default: in_ready = 1'b0;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lpst_pkg::S_IDLE;
			rd_cnt_q   <= '0;
			cmp_vld_s2 <= 1'b0;
			hit_q      <= 1'b0;
			valid_q    <= '0;
			count_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == lpst_pkg::S_IDLE && in_valid) begin
				rd_cnt_q   <= '0;
				cmp_vld_s2 <= 1'b0;
				hit_q      <= 1'b0;
			end
			// Advance the read pointer and compare stage
			if (advance) begin
				if (scan_more) begin
					rd_cnt_q   <= lpst_pkg::SCAN_W'(rd_cnt_q + 1'b1);
					cmp_vld_s2 <= 1'b1;
				end else begin
					cmp_vld_s2 <= 1'b0;
				end
				if (match && !hit_q) begin
					hit_q <= 1'b1;
				end
			end
			// Commit table updates
			if (upd_add) begin
				valid_q[free_idx] <= 1'b1;
				count_q           <= lpst_pkg::COUNT_W'(count_q + 1'b1);
			end
			if (upd_rem) begin
				valid_q[hit_idx_q] <= 1'b0;
				count_q            <= lpst_pkg::COUNT_W'(count_q - 1'b1);
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == lpst_pkg::S_IDLE && in_valid) begin
			action_q <= lpst_pkg::action_t'(in_action);
			id_q     <= lpst_pkg::TILE_ID_BITS'(in_id);
		end
		if (advance && scan_more) begin
			cmp_idx_s2 <= rd_cnt_q[lpst_pkg::SLOT_W-1:0];
		end
		if (advance && match && !hit_q) begin
			hit_idx_q <= cmp_idx_s2;
		end
	end

endmodule

[rtl/lpst_out_reg.sv]
module lpst_out_reg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               res_push,
	input  lpst_pkg::res_t                     res,
	output logic                               res_ready,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [lpst_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output logic                               m_tuser,
	output logic                               m_tlast
);

	logic           vld_q;
	lpst_pkg::res_t res_q;

	// Take a new item when empty or when the held one leaves this cycle
	assign res_ready = !vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (res_ready) begin
			vld_q <= res_push;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push && res_ready) begin
			res_q <= res;
		end
	end

	// Pack: status, present, listed_sharer, sharer_count, zero fill
	assign m_tvalid = vld_q;
	assign m_tdata  = lpst_pkg::OUT_TDATA_W'({res_q.sharer_count, res_q.listed_sharer,
		res_q.present, res_q.status});
	assign m_tuser  = res_q.listed_valid;
	assign m_tlast  = res_q.last;

endmodule

[rtl/limited_pointer_sharer_table_core.sv]
// Sharer table: one item is taken, then all MAX_SHARERS slots are read from the
// id memory one per cycle, unless a full output register stalls a list scan, and
// compared in the following cycle; the scan is set by the single read port of the id memory.
// Single results are pushed once the scan ends; list results are pushed to the output register
// as their slot is compared, and a full output register stalls the scan.
// Reset clears valid bits, count and control; the id memory is not cleared.
`include "limited_pointer_sharer_table_core_assert.svh"

module limited_pointer_sharer_table_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [1:0] action, [11:2] tile_id, [15:12] zero
	input  logic [lpst_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [1:0] status, [2] present, [12:3] listed_sharer, [16:13] sharer_count, rest zero
	output logic [lpst_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// [0] listed_valid
	output logic                               m_tuser,
	output logic                               m_tlast
);

	logic                            ram_rd_en;
	logic [lpst_pkg::SLOT_W-1:0]     ram_rd_addr;
	lpst_pkg::id_t                   ram_rd_data;
	logic                            ram_wr_en;
	logic [lpst_pkg::SLOT_W-1:0]     ram_wr_addr;
	lpst_pkg::id_t                   ram_wr_data;
	logic                            res_push;
	lpst_pkg::res_t                  res;
	logic                            res_ready;

	// Slot id storage
	lpst_id_ram #(
		.DEPTH (lpst_pkg::MAX_SHARERS),
		.WIDTH (lpst_pkg::TILE_ID_BITS)
	) u_id_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// Scan and update sequencer
	lpst_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_action   (s_tdata[1:0]),
		.in_id       (s_tdata[11:2]),
		.ram_rd_en   (ram_rd_en),
		.ram_rd_addr (ram_rd_addr),
		.ram_rd_data (ram_rd_data),
		.ram_wr_en   (ram_wr_en),
		.ram_wr_addr (ram_wr_addr),
		.ram_wr_data (ram_wr_data),
		.res_push    (res_push),
		.res         (res),
		.res_ready   (res_ready)
	);

	// Output register
	lpst_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_push  (res_push),
		.res       (res),
		.res_ready (res_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// One item in flight at a time
	`LPST_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
	// A result without a listed id always closes its item
	`LPST_ASSERT_NOW(a_unlisted_is_last, m_tvalid && !m_tuser, m_tlast)
	// Error codes come only on single, non-list results
	`LPST_ASSERT_NOW(a_error_single, m_tvalid && (m_tdata[1:0] != 2'(lpst_pkg::ST_OK)),
		m_tlast && !m_tuser)
	// A listed id never carries a presence flag
	`LPST_ASSERT_NOW(a_list_no_present, m_tvalid && m_tuser, !m_tdata[2])

endmodule

[dv/limited_pointer_sharer_table_core_test.sv]
`timescale 1ns / 100ps

module limited_pointer_sharer_table_core_test;

	// One expected result transfer
	typedef struct {
		lpst_pkg::status_t             status;
		logic                          present;
		logic                          listed_valid;
		lpst_pkg::id_t                 listed_sharer;
		logic                          last;
		logic [lpst_pkg::COUNT_W-1:0]  sharer_count;
	} sharer_result_t;

	logic                              clk;
	logic                              arst_n;
	logic                              s_tvalid;
	logic                              s_tready;
	// [1:0] action, [11:2] tile_id, [15:12] zero
	logic [lpst_pkg::IN_TDATA_W-1:0]   s_tdata;
	logic                              m_tvalid;
	logic                              m_tready;
	// [1:0] status, [2] present, [12:3] listed_sharer, [16:13] sharer_count, rest zero
	logic [lpst_pkg::OUT_TDATA_W-1:0]  m_tdata;
	// [0] listed_valid
	logic                              m_tuser;
	logic                              m_tlast;

	// Mirror of the table contents
	lpst_pkg::id_t                 mirror_ids [lpst_pkg::MAX_SHARERS];
	logic                          mirror_used [lpst_pkg::MAX_SHARERS];
	logic [lpst_pkg::COUNT_W-1:0]  mirror_count;

	sharer_result_t pending_results [$];
	int errors;
	int tx_idle_pct;
	int rx_idle_pct;
	int rx_hold;

	limited_pointer_sharer_table_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Return the slot holding id, or -1
	function automatic int find_holder(lpst_pkg::id_t id);
		for (int i = 0; i < lpst_pkg::MAX_SHARERS; i++)
			if (mirror_used[i] && mirror_ids[i] == id)
				return i;
		return -1;
	endfunction

	// Update the mirror for one accepted command and queue the results it causes
	function automatic void predict_table(lpst_pkg::action_t act, lpst_pkg::id_t id);
		sharer_result_t r;
		int hit;
		int seen;
		logic placed;
		r.status = lpst_pkg::ST_OK;
		r.present = 1'b0;
		r.listed_valid = 1'b0;
		r.listed_sharer = '0;
		r.last = 1'b1;
		r.sharer_count = '0;
		hit = find_holder(id);
		seen = 0;
		placed = 1'b0;
		case (act)
			lpst_pkg::ACT_QUERY: begin
				r.present = (hit >= 0);
			end
			lpst_pkg::ACT_ADD: begin
				if (hit >= 0) begin
					r.status = lpst_pkg::ST_DUP;
				end else begin
					r.status = lpst_pkg::ST_FULL;
					for (int i = 0; i < lpst_pkg::MAX_SHARERS; i++) begin
						if (!placed && !mirror_used[i]) begin
							placed = 1'b1;
							mirror_used[i] = 1'b1;
							mirror_ids[i] = id;
							mirror_count = mirror_count + 1'b1;
							r.status = lpst_pkg::ST_OK;
						end
					end
				end
			end
			lpst_pkg::ACT_REMOVE: begin
				if (hit < 0) begin
					r.status = lpst_pkg::ST_NOT_FOUND;
				end else begin
					mirror_used[hit] = 1'b0;
					mirror_count = mirror_count - 1'b1;
				end
			end
			default: begin
				// One transfer per held slot in slot order; empty table gives one marker
				r.sharer_count = mirror_count;
				for (int i = 0; i < lpst_pkg::MAX_SHARERS; i++) begin
					if (mirror_used[i]) begin
						seen++;
						r.listed_valid = 1'b1;
						r.listed_sharer = mirror_ids[i];
						r.last = (seen == mirror_count);
						pending_results = {pending_results, r};
					end
				end
				if (seen == 0)
					pending_results = {pending_results, r};
				return;
			end
		endcase
		r.sharer_count = mirror_count;
		pending_results = {pending_results, r};
	endfunction

	// Offer one command, idling first at the current rate, and wait for the transfer
	task automatic send_cmd(input lpst_pkg::action_t act, input lpst_pkg::id_t id);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= lpst_pkg::IN_TDATA_W'($urandom);
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, id, act};
		do @(posedge clk); while (!s_tready);
		predict_table(act, id);
	endtask

	task automatic release_bus();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	// Hold the sender until every queued result has come back or the wait gives up
	task automatic drain_results();
		release_bus();
		for (int c = 0; c < 20000 && pending_results.size() != 0; c++)
			@(posedge clk);
	endtask

	task automatic check_field(input string what, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			errors++;
		end
	endtask

	// Receiver readiness: long hold when requested, else random stalls
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Compare each result transfer against the oldest expectation
	always @(posedge clk) begin
		sharer_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual tdata=%h tuser=%b tlast=%b",
					$time, m_tdata, m_tuser, m_tlast);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", 16'(want.status), 16'(m_tdata[1:0]));
				check_field("present", 16'(want.present), 16'(m_tdata[2]));
				check_field("listed_sharer", 16'(want.listed_sharer), 16'(m_tdata[12:3]));
				check_field("sharer_count", 16'(want.sharer_count), 16'(m_tdata[16:13]));
				check_field("listed_valid", 16'(want.listed_valid), 16'(m_tuser));
				check_field("last", 16'(want.last), 16'(m_tlast));
			end
		end
	end

	// Empty table, edge ids, duplicates, full table, absent removes, slot reuse
	task automatic test_directed();
		send_cmd(lpst_pkg::ACT_LIST, 10'd0);
		send_cmd(lpst_pkg::ACT_QUERY, 10'd0);
		send_cmd(lpst_pkg::ACT_REMOVE, 10'd1023);
		send_cmd(lpst_pkg::ACT_ADD, 10'd0);
		send_cmd(lpst_pkg::ACT_ADD, 10'd1023);
		send_cmd(lpst_pkg::ACT_ADD, 10'd0);
		send_cmd(lpst_pkg::ACT_QUERY, 10'd0);
		send_cmd(lpst_pkg::ACT_QUERY, 10'd1023);
		send_cmd(lpst_pkg::ACT_QUERY, 10'd512);
		send_cmd(lpst_pkg::ACT_LIST, 10'd1023);
		send_cmd(lpst_pkg::ACT_ADD, 10'h155);
		send_cmd(lpst_pkg::ACT_ADD, 10'h2aa);
		send_cmd(lpst_pkg::ACT_ADD, 10'd1);
		send_cmd(lpst_pkg::ACT_ADD, 10'd2);
		send_cmd(lpst_pkg::ACT_ADD, 10'd3);
		send_cmd(lpst_pkg::ACT_ADD, 10'd4);
		send_cmd(lpst_pkg::ACT_ADD, 10'd5);
		send_cmd(lpst_pkg::ACT_LIST, 10'h2aa);
		send_cmd(lpst_pkg::ACT_REMOVE, 10'd1023);
		send_cmd(lpst_pkg::ACT_REMOVE, 10'd1023);
		send_cmd(lpst_pkg::ACT_ADD, 10'd5);
		send_cmd(lpst_pkg::ACT_LIST, 10'd0);
		drain_results();
	endtask

	// Stall the output for a long stretch while lists keep coming, then drain
	task automatic test_backpressure();
		send_cmd(lpst_pkg::ACT_LIST, 10'd0);
		rx_hold = 300;
		send_cmd(lpst_pkg::ACT_LIST, 10'd7);
		send_cmd(lpst_pkg::ACT_QUERY, 10'd5);
		send_cmd(lpst_pkg::ACT_LIST, 10'd9);
		send_cmd(lpst_pkg::ACT_ADD, 10'd6);
		send_cmd(lpst_pkg::ACT_LIST, 10'd11);
		drain_results();
	endtask

	// Mostly hits on a small id pool so the table fills and empties often
	task automatic test_random_mix(input int count, input int tx_pct, input int rx_pct);
		lpst_pkg::id_t id_pool [12];
		lpst_pkg::id_t id;
		lpst_pkg::action_t act;
		int pick;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		foreach (id_pool[i])
			id_pool[i] = lpst_pkg::id_t'($urandom_range(1023));
		if ($urandom_range(1)) begin
			id_pool[0] = '0;
			id_pool[1] = '1;
		end
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 35)
				act = lpst_pkg::ACT_ADD;
			else if (pick < 65)
				act = lpst_pkg::ACT_REMOVE;
			else if (pick < 85)
				act = lpst_pkg::ACT_QUERY;
			else
				act = lpst_pkg::ACT_LIST;
			if ($urandom_range(99) < 80)
				id = id_pool[$urandom_range(11)];
			else
				id = lpst_pkg::id_t'($urandom_range(1023));
			send_cmd(act, id);
		end
		drain_results();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		errors = 0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold = 0;
		mirror_count = '0;
		foreach (mirror_used[i]) begin
			mirror_used[i] = 1'b0;
			mirror_ids[i] = '0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_backpressure();
		test_random_mix(44, 14, 60);
		test_random_mix(44, 60, 14);
		test_random_mix(44, 0, 0);

		repeat (30) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t ns: %0d results missing, expected %0d, actual 0", $time,
				pending_results.size(), pending_results.size());
			errors++;
		end
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule
